### rtl/price_level_order_book_unit_defines.svh
// ---------------------------------------------------------------------------
// price_level_order_book_unit_defines
// Assertion macros shared by the order book checker.
// ---------------------------------------------------------------------------
`ifndef PRICE_LEVEL_ORDER_BOOK_UNIT_DEFINES_SVH
`define PRICE_LEVEL_ORDER_BOOK_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define PLOB_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define PLOB_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/plob_pkg.sv
// ---------------------------------------------------------------------------
// plob_pkg
// Types, widths and codes of the price level order book.
// ---------------------------------------------------------------------------
package plob_pkg;

	localparam int NUM_SYMBOLS_DEF = 8;
	localparam int DEPTH_DEF       = 10;
	localparam int ORDER_SLOTS_DEF = 1024;

	localparam int PRICE_W = 32;
	localparam int QTY_W   = 40;
	localparam int LQTY_W  = 48;

	localparam logic [1:0] STS_OK       = 2'd0;
	localparam logic [1:0] STS_NO_BOOK  = 2'd1;
	localparam logic [1:0] STS_NO_ORDER = 2'd2;

	localparam logic KIND_ADD = 1'b0;
	localparam logic KIND_MOD = 1'b1;
	localparam logic SIDE_BID = 1'b0;
	localparam logic SIDE_ASK = 1'b1;

	typedef struct packed {
		logic               kind;
		logic [2:0]         symbol_index;
		logic               side;
		logic [9:0]         order_slot;
		logic [PRICE_W-1:0] price;
		logic [QTY_W-1:0]   qty;
		logic               remove;
	} req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic               out_side;
		logic [3:0]         level_index;
		logic [PRICE_W-1:0] level_price;
		logic [LQTY_W-1:0]  level_qty;
		logic               level_valid;
		logic               last;
	} rsp_t;

	typedef struct packed {
		logic [PRICE_W-1:0] price;
		logic [LQTY_W-1:0]  qty;
	} level_t;

	typedef struct packed {
		logic load;
		logic look;
		logic apply;
		logic shift;
		logic kind;
		logic side;
	} cell_ctl_t;

endpackage

### rtl/plob_cell.sv
// ---------------------------------------------------------------------------
// plob_cell
// One level position of the book, for every book side, with its work register.
// ---------------------------------------------------------------------------
module plob_cell import plob_pkg::*; #(
	parameter int NSD   = 16,
	parameter int SD_W  = 4,
	parameter int CNT_W = 4,
	parameter int IDX   = 0
) (
	input  logic               clk,
	input  cell_ctl_t          ctl,
	input  logic [SD_W-1:0]    addr,
	input  logic [CNT_W-1:0]   cnt,
	input  logic [PRICE_W-1:0] price,
	input  logic [QTY_W-1:0]   qty,
	input  logic               any_e,
	input  logic               any_d,
	input  level_t             left_lvl,
	input  level_t             right_lvl,
	input  logic               left_b,
	output level_t             lvl,
	output logic               b,
	output logic               e,
	output logic               d
);

	level_t mem [NSD];
	level_t lvl_q;
	level_t nxt;
	logic   b_q, e_q, d_q;
	logic   live;
	logic   better;
	logic [LQTY_W:0] sum;

	assign live   = CNT_W'(IDX) < cnt;
	assign better = (ctl.side == SIDE_BID) ? (lvl_q.price > price) : (lvl_q.price < price);
	assign sum    = {1'b0, lvl_q.qty} + (LQTY_W + 1)'(qty);

	always_comb begin
		nxt = lvl_q;
		if (ctl.kind == KIND_ADD) begin
			if (any_e) begin
				if (e_q)
					nxt.qty = sum[LQTY_W] ? {LQTY_W{1'b1}} : sum[LQTY_W-1:0];
			end else if (left_b && !b_q) begin
				nxt.price = price;
				nxt.qty   = LQTY_W'(qty);
			end else if (!left_b) begin
				nxt = left_lvl;
			end
		end else begin
			if (any_e) begin
				if (any_d) begin
					// close the gap: everything at or after the match moves up
					if (!b_q)
						nxt = right_lvl;
				end else if (e_q) begin
					nxt.qty = lvl_q.qty - LQTY_W'(qty);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.apply)
			mem[addr] <= nxt;
		if (ctl.load)
			lvl_q <= mem[addr];
		else if (ctl.apply)
			lvl_q <= nxt;
		else if (ctl.shift)
			lvl_q <= right_lvl;
		if (ctl.look) begin
			b_q <= live && better;
			e_q <= live && (lvl_q.price == price);
			d_q <= live && (lvl_q.price == price) && (LQTY_W'(qty) >= lvl_q.qty);
		end
	end

	assign lvl = lvl_q;
	assign b   = b_q;
	assign e   = e_q;
	assign d   = d_q;

endmodule

### rtl/price_level_order_book_unit.sv
// ---------------------------------------------------------------------------
// price_level_order_book_unit
// Per-symbol bid/ask books of aggregated price levels kept in a chain of cells.
// ---------------------------------------------------------------------------
// Requests: the next request is taken only after the last result beat of the previous one.
// Results: one beat per level reported, a single beat for an empty side or an
//   error; one level leaves the chain head per beat.
// Reset: all books empty; a clearing pass over the order table follows, with
//   req_ready low until it ends.
module price_level_order_book_unit import plob_pkg::*; #(
	parameter int NUM_SYMBOLS = NUM_SYMBOLS_DEF,
	parameter int DEPTH       = DEPTH_DEF,
	parameter int ORDER_SLOTS = ORDER_SLOTS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	localparam int NSD       = 2 * NUM_SYMBOLS;
	localparam int SD_W      = $clog2(NSD);
	localparam int SYM_W     = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;
	localparam int CNT_W     = $clog2(DEPTH + 1);
	localparam int O_ENTRIES = NUM_SYMBOLS * ORDER_SLOTS;
	localparam int OADDR_W   = $clog2(O_ENTRIES);

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_LOOK  = 3'd2;
	localparam logic [2:0] S_APPLY = 3'd3;
	localparam logic [2:0] S_EMIT  = 3'd4;

	typedef struct packed {
		logic               valid;
		logic [PRICE_W-1:0] price;
	} ord_t;

	logic [2:0]         state_q;
	logic [OADDR_W-1:0] clr_q;
	req_t               req_q;
	ord_t               omem [O_ENTRIES];
	ord_t               ord_rd_q;
	logic [NUM_SYMBOLS-1:0] present_q;
	logic [CNT_W-1:0]   lcnt_q [NSD];
	logic [1:0]         sts_q;
	logic [CNT_W-1:0]   emit_n_q;
	logic [CNT_W-1:0]   idx_q;

	logic               accept;
	logic [31:0]        sym_in32, sym32, sd_in32, sd32, oa_in32, oa32;
	logic [SD_W-1:0]    sd_in, sd_q, cell_addr;
	logic [SYM_W-1:0]   sym_idx;
	logic [OADDR_W-1:0] oaddr_in, oaddr_q;
	logic               sym_ok, slot_ok;
	logic [1:0]         err;
	logic [PRICE_W-1:0] tgt;
	logic [CNT_W-1:0]   n_cur, n_new;
	logic               any_e, any_d, ins_ok;
	logic               rsp_last;
	logic [31:0]        idx32;
	cell_ctl_t          ctl;

	level_t             lvl   [DEPTH];
	logic [DEPTH-1:0]   b_vec, e_vec, d_vec;

	assign accept   = (state_q == S_IDLE) && req_valid;
	assign sym_in32 = 32'(req.symbol_index);
	assign sym32    = 32'(req_q.symbol_index);
	assign sd_in32  = {sym_in32[30:0], req.side};
	assign sd32     = {sym32[30:0], req_q.side};
	assign sd_in    = sd_in32[SD_W-1:0];
	assign sd_q     = sd32[SD_W-1:0];
	assign sym_idx  = sym32[SYM_W-1:0];
	assign oa_in32  = sym_in32 * 32'(ORDER_SLOTS) + 32'(req.order_slot);
	assign oa32     = sym32 * 32'(ORDER_SLOTS) + 32'(req_q.order_slot);
	assign oaddr_in = oa_in32[OADDR_W-1:0];
	assign oaddr_q  = oa32[OADDR_W-1:0];
	assign sym_ok   = sym32 < 32'(NUM_SYMBOLS);
	assign slot_ok  = 32'(req_q.order_slot) < 32'(ORDER_SLOTS);
	assign tgt      = (req_q.kind == KIND_MOD) ? ord_rd_q.price : req_q.price;
	assign n_cur    = lcnt_q[sd_q];

	always_comb begin
		if (!sym_ok || (req_q.kind == KIND_MOD && !present_q[sym_idx]))
			err = STS_NO_BOOK;
		else if (req_q.kind == KIND_MOD && (!slot_ok || !ord_rd_q.valid))
			err = STS_NO_ORDER;
		else
			err = STS_OK;
	end

	assign any_e  = |e_vec;
	assign any_d  = |d_vec;
	assign ins_ok = !b_vec[DEPTH-1];

	always_comb begin
		n_new = n_cur;
		if (req_q.kind == KIND_ADD) begin
			if (!any_e && ins_ok && n_cur != CNT_W'(DEPTH))
				n_new = n_cur + CNT_W'(1);
		end else if (any_e && any_d) begin
			n_new = n_cur - CNT_W'(1);
		end
	end

	assign rsp_last  = (emit_n_q == '0) || ((idx_q + CNT_W'(1)) == emit_n_q);
	assign cell_addr = (state_q == S_IDLE) ? sd_in : sd_q;

	assign ctl.load  = accept;
	assign ctl.look  = (state_q == S_LOOK) && (err == STS_OK);
	assign ctl.apply = (state_q == S_APPLY);
	assign ctl.shift = (state_q == S_EMIT) && rsp_ready && !rsp_last;
	assign ctl.kind  = req_q.kind;
	assign ctl.side  = req_q.side;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		level_t lft, rgt;
		logic   lft_b;
		if (i == 0) begin : g_head
			assign lft   = '0;
			assign lft_b = 1'b1;
		end else begin : g_body
			assign lft   = lvl[i-1];
			assign lft_b = b_vec[i-1];
		end
		if (i == DEPTH - 1) begin : g_tail
			assign rgt = '0;
		end else begin : g_inner
			assign rgt = lvl[i+1];
		end
		plob_cell #(
			.NSD   (NSD),
			.SD_W  (SD_W),
			.CNT_W (CNT_W),
			.IDX   (i)
		) u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.addr      (cell_addr),
			.cnt       (n_cur),
			.price     (tgt),
			.qty       (req_q.qty),
			.any_e     (any_e),
			.any_d     (any_d),
			.left_lvl  (lft),
			.right_lvl (rgt),
			.left_b    (lft_b),
			.lvl       (lvl[i]),
			.b         (b_vec[i]),
			.e         (e_vec[i]),
			.d         (d_vec[i])
		);
	end

	// order table: clearing pass, then at most one write per request
	always_ff @(posedge clk) begin
		if (state_q == S_CLEAR)
			omem[clr_q] <= '0;
		else if (state_q == S_APPLY && slot_ok) begin
			if (req_q.kind == KIND_ADD)
				omem[oaddr_q] <= {1'b1, req_q.price};
			else if (req_q.remove)
				omem[oaddr_q] <= {1'b0, ord_rd_q.price};
		end
		if (accept)
			ord_rd_q <= omem[oaddr_in];
	end

	always_ff @(posedge clk) begin
		if (accept)
			req_q <= req;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			clr_q     <= '0;
			present_q <= '0;
			for (int k = 0; k < NSD; k++)
				lcnt_q[k] <= '0;
			sts_q     <= STS_OK;
			emit_n_q  <= '0;
			idx_q     <= '0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + OADDR_W'(1);
					if (clr_q == OADDR_W'(O_ENTRIES - 1))
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (accept)
						state_q <= S_LOOK;
				end
				S_LOOK: begin
					idx_q <= '0;
					sts_q <= err;
					if (err != STS_OK) begin
						emit_n_q <= '0;
						state_q  <= S_EMIT;
					end else begin
						state_q  <= S_APPLY;
					end
				end
				S_APPLY: begin
					if (req_q.kind == KIND_ADD)
						present_q[sym_idx] <= 1'b1;
					lcnt_q[sd_q] <= n_new;
					emit_n_q     <= n_new;
					state_q      <= S_EMIT;
				end
				S_EMIT: begin
					if (rsp_ready) begin
						if (rsp_last)
							state_q <= S_IDLE;
						else
							idx_q <= idx_q + CNT_W'(1);
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign idx32     = 32'(idx_q);
	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = (state_q == S_EMIT);

	always_comb begin
		rsp.status      = sts_q;
		rsp.out_side    = req_q.side;
		rsp.level_valid = (emit_n_q != '0);
		rsp.level_index = rsp.level_valid ? idx32[3:0] : 4'd0;
		rsp.level_price = rsp.level_valid ? lvl[0].price : '0;
		rsp.level_qty   = rsp.level_valid ? lvl[0].qty : '0;
		rsp.last        = rsp_last;
	end

endmodule

### rtl/plob_checker.sv
// ---------------------------------------------------------------------------
// plob_checker
// Port-level checks of the order book, bound to the top level.
// ---------------------------------------------------------------------------
`include "price_level_order_book_unit_defines.svh"

module plob_checker import plob_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input req_t req,
	input logic rsp_valid,
	input logic rsp_ready,
	input rsp_t rsp
);

	`PLOB_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp), "rsp beat changed while stalled")
	`PLOB_ASSERT_NXT(a_busy_after_req, req_valid && req_ready, !req_ready, "second request taken while busy")
	`PLOB_ASSERT_IMP(a_empty_is_last, rsp_valid && !rsp.level_valid, rsp.last, "empty or error beat not last")
	`PLOB_ASSERT_IMP(a_err_no_level, rsp_valid && rsp.status != STS_OK, !rsp.level_valid && rsp.level_index == 4'd0, "error beat carries a level")
	`PLOB_ASSERT_NXT(a_index_step, rsp_valid && rsp_ready && !rsp.last, rsp_valid && rsp.level_index == 4'($past(rsp.level_index) + 4'd1), "level index did not advance")

endmodule

bind price_level_order_book_unit plob_checker u_plob_checker (.*);

### dv/plob_checker.sv
// ---------------------------------------------------------------------------
// plob_scoreboard
// Watches the request and response channels of the order book, keeps its own
// copy of every book and order table, and compares each response beat.
// ---------------------------------------------------------------------------
module plob_scoreboard import plob_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	input  logic req_ready,
	input  req_t req,
	input  logic rsp_valid,
	input  logic rsp_ready,
	input  rsp_t rsp,
	output int   fail_count,
	output int   pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NSYM  = NUM_SYMBOLS_DEF;
	localparam int DEPTH = DEPTH_DEF;
	localparam int SLOTS = ORDER_SLOTS_DEF;
	localparam logic [LQTY_W-1:0] LQTY_MAX = '1;

	logic                book_live [NSYM];
	int                  lvl_cnt   [NSYM*2];
	logic [PRICE_W-1:0]  lvl_px    [NSYM*2][DEPTH];
	logic [LQTY_W-1:0]   lvl_qty   [NSYM*2][DEPTH];
	logic                slot_live [NSYM*SLOTS];
	logic [PRICE_W-1:0]  slot_px   [NSYM*SLOTS];
	rsp_t                expected_beats[$];

	function automatic bit ranks_ahead(logic sd, logic [PRICE_W-1:0] a, logic [PRICE_W-1:0] b);
		return sd ? (a < b) : (a > b);
	endfunction

	function automatic void queue_beat(rsp_t b);
		expected_beats = {expected_beats, b};
	endfunction

	function automatic void merge_level(int bs, logic sd, logic [PRICE_W-1:0] px,
			logic [QTY_W-1:0] q);
		int n;
		int pos;
		logic [LQTY_W:0] sum;
		n = lvl_cnt[bs];
		pos = 0;
		while (pos < n && ranks_ahead(sd, lvl_px[bs][pos], px)) pos++;
		if (pos < n && lvl_px[bs][pos] == px) begin
			sum = lvl_qty[bs][pos] + q;
			lvl_qty[bs][pos] = sum[LQTY_W] ? LQTY_MAX : sum[LQTY_W-1:0];
			return;
		end
		if (pos >= DEPTH) return;
		// worst level falls off a full side
		if (n >= DEPTH) n = DEPTH - 1;
		for (int i = n; i > pos; i--) begin
			lvl_px[bs][i] = lvl_px[bs][i-1];
			lvl_qty[bs][i] = lvl_qty[bs][i-1];
		end
		lvl_px[bs][pos] = px;
		lvl_qty[bs][pos] = LQTY_W'(q);
		lvl_cnt[bs] = n + 1;
	endfunction

	function automatic void reduce_level(int bs, logic [PRICE_W-1:0] px, logic [QTY_W-1:0] q);
		int n;
		int pos;
		n = lvl_cnt[bs];
		for (pos = 0; pos < n; pos++)
			if (lvl_px[bs][pos] == px) break;
		// orphaned order: its level is already gone
		if (pos >= n) return;
		if (LQTY_W'(q) >= lvl_qty[bs][pos]) begin
			for (int i = pos; i + 1 < n; i++) begin
				lvl_px[bs][i] = lvl_px[bs][i+1];
				lvl_qty[bs][i] = lvl_qty[bs][i+1];
			end
			lvl_cnt[bs] = n - 1;
		end else begin
			lvl_qty[bs][pos] -= LQTY_W'(q);
		end
	endfunction

	function automatic void predict_book(req_t r);
		rsp_t b;
		int bs;
		int oi;
		b = '0;
		b.out_side = r.side;
		b.last = 1'b1;
		if (r.symbol_index >= NSYM || (r.kind == KIND_MOD && !book_live[r.symbol_index])) begin
			b.status = STS_NO_BOOK;
			queue_beat(b);
			return;
		end
		bs = r.symbol_index * 2 + r.side;
		oi = r.symbol_index * SLOTS + r.order_slot;
		if (r.kind == KIND_ADD) begin
			book_live[r.symbol_index] = 1'b1;
			merge_level(bs, r.side, r.price, r.qty);
			if (r.order_slot < SLOTS) begin
				slot_live[oi] = 1'b1;
				slot_px[oi] = r.price;
			end
		end else begin
			if (r.order_slot >= SLOTS || !slot_live[oi]) begin
				b.status = STS_NO_ORDER;
				queue_beat(b);
				return;
			end
			reduce_level(bs, slot_px[oi], r.qty);
			if (r.remove) slot_live[oi] = 1'b0;
		end
		if (lvl_cnt[bs] == 0) begin
			b.status = STS_OK;
			queue_beat(b);
			return;
		end
		for (int i = 0; i < lvl_cnt[bs]; i++) begin
			b = '0;
			b.status = STS_OK;
			b.out_side = r.side;
			b.level_index = 4'(i);
			b.level_price = lvl_px[bs][i];
			b.level_qty = lvl_qty[bs][i];
			b.level_valid = 1'b1;
			b.last = (i + 1 == lvl_cnt[bs]);
			queue_beat(b);
		end
	endfunction

	initial begin
		fail_count = 0;
		pending = 0;
		foreach (book_live[i]) book_live[i] = 1'b0;
		foreach (lvl_cnt[i]) lvl_cnt[i] = 0;
		foreach (slot_live[i]) slot_live[i] = 1'b0;
	end

	always @(posedge clk) begin
		rsp_t want;
		if (arst_n) begin
			if (rsp_valid && rsp_ready) begin
				if (expected_beats.size() == 0) begin
					$error("response beat with nothing expected: %p", rsp);
					fail_count++;
				end else begin
					want = expected_beats.pop_front();
					if (rsp.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, rsp.status);
						fail_count++;
					end
					if (rsp.out_side !== want.out_side) begin
						$error("out_side: expected %0d, got %0d", want.out_side, rsp.out_side);
						fail_count++;
					end
					if (rsp.level_index !== want.level_index) begin
						$error("level_index: expected %0d, got %0d",
							want.level_index, rsp.level_index);
						fail_count++;
					end
					if (rsp.level_price !== want.level_price) begin
						$error("level_price: expected %0h, got %0h",
							want.level_price, rsp.level_price);
						fail_count++;
					end
					if (rsp.level_qty !== want.level_qty) begin
						$error("level_qty: expected %0h, got %0h", want.level_qty, rsp.level_qty);
						fail_count++;
					end
					if (rsp.level_valid !== want.level_valid) begin
						$error("level_valid: expected %0d, got %0d",
							want.level_valid, rsp.level_valid);
						fail_count++;
					end
					if (rsp.last !== want.last) begin
						$error("last: expected %0d, got %0d", want.last, rsp.last);
						fail_count++;
					end
				end
			end
			// predict after popping so a same-edge request cannot confuse ordering
			if (req_valid && req_ready) predict_book(req);
			pending <= expected_beats.size();
		end
	end
endmodule

### dv/tb.sv
// ---------------------------------------------------------------------------
// tb
// Drives adds and modifies into the price level order book with random gaps
// and back-pressure; the checker predicts and compares every response beat.
// ---------------------------------------------------------------------------
module tb import plob_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_ORDERS = 240;
	localparam int CYCLE_LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;
	int   fail_count;
	int   pending;
	int   cycles = 0;
	int   beats_seen = 0;
	bit   hold_rsp = 1'b0;
	bit   stim_done = 1'b0;
	logic [PRICE_W-1:0] px_pool [8];

	always #1 clk = ~clk;

	price_level_order_book_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
	);

	plob_scoreboard chk (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
		.fail_count(fail_count), .pending(pending)
	);

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (rsp_valid && rsp_ready) beats_seen <= beats_seen + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// response side: random stalls, one long hold-off on request
	initial begin
		int g;
		bit hold_done;
		hold_done = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_rsp && !hold_done) begin
				rsp_ready <= 1'b0;
				repeat (199) @(negedge clk);
				hold_done = 1'b1;
			end else begin
				g = stim_done ? 0 : gap_len();
				if (g > 0) begin
					rsp_ready <= 1'b0;
					repeat (g - 1) @(negedge clk);
				end else begin
					rsp_ready <= 1'b1;
				end
			end
		end
	end

	// valid stays up between back-to-back beats; the caller drops it at the end
	task automatic send_beat(req_t r);
		int g;
		g = gap_len();
		if (g > 0) begin
			req_valid <= 1'b0;
			repeat (g) @(negedge clk);
		end
		req <= r;
		req_valid <= 1'b1;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		@(negedge clk);
	endtask

	function automatic req_t make_order(logic kind, logic [2:0] sym, logic sd,
			logic [9:0] slot, logic [PRICE_W-1:0] px, logic [QTY_W-1:0] q, logic rm);
		req_t r;
		r.kind = kind;
		r.symbol_index = sym;
		r.side = sd;
		r.order_slot = slot;
		r.price = px;
		r.qty = q;
		r.remove = rm;
		return r;
	endfunction

	function automatic req_t random_order();
		req_t r;
		int pick;
		r.kind = ($urandom_range(0, 99) < 45) ? KIND_MOD : KIND_ADD;
		r.symbol_index = 3'(($urandom_range(0, 9) < 7) ? $urandom_range(0, 2)
			: $urandom_range(0, 7));
		r.side = ($urandom_range(0, 1) == 0) ? SIDE_BID : SIDE_ASK;
		r.order_slot = 10'(($urandom_range(0, 9) < 8) ? $urandom_range(0, 15) : $urandom());
		pick = $urandom_range(0, 9);
		// a small pool of prices makes merges and modifies hit real levels
		r.price = (pick < 8) ? px_pool[$urandom_range(0, 7)] : $urandom();
		pick = $urandom_range(0, 9);
		if (pick < 6) r.qty = 40'($urandom_range(1, 1000));
		else if (pick < 9) r.qty = 40'({$urandom(), $urandom()});
		else r.qty = '1;
		r.remove = ($urandom_range(0, 1) == 0) ? 1'b0 : 1'b1;
		return r;
	endfunction

	initial begin
		logic sd;
		for (int i = 0; i < 8; i++) px_pool[i] = 32'(1000 + 10 * i);
		px_pool[6] = '1;
		px_pool[7] = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: error paths, extremes, merge, saturation, depth eviction
		send_beat(make_order(KIND_MOD, 3'd0, SIDE_BID, 10'd0, 32'd0, 40'd5, 1'b0));
		send_beat(make_order(KIND_ADD, 3'd0, SIDE_BID, 10'd0, '1, '1, 1'b0));
		send_beat(make_order(KIND_ADD, 3'd0, SIDE_BID, 10'd1, '1, '1, 1'b0));
		for (int i = 0; i < 257; i += 32)
			send_beat(make_order(KIND_ADD, 3'd0, SIDE_BID, 10'd1, '1, '1, 1'b0));
		send_beat(make_order(KIND_MOD, 3'd0, SIDE_BID, 10'd1023, 32'd0, 40'd1, 1'b1));
		send_beat(make_order(KIND_MOD, 3'd7, SIDE_ASK, 10'd0, 32'd0, 40'd1, 1'b0));
		for (int i = 0; i < 11; i++) begin
			sd = i[0];
			send_beat(make_order(KIND_ADD, 3'd1, sd, 10'(2 + i), 32'(100 + 7 * i),
				40'(50 + i), 1'b0));
		end
		for (int i = 0; i < 12; i++)
			send_beat(make_order(KIND_ADD, 3'd2, SIDE_ASK, 10'(20 + i), 32'(500 - 3 * i),
				40'd10, 1'b0));
		send_beat(make_order(KIND_ADD, 3'd2, SIDE_ASK, 10'd40, 32'd9999, 40'd1, 1'b0));
		send_beat(make_order(KIND_MOD, 3'd2, SIDE_ASK, 10'd20, 32'd0, 40'd3, 1'b0));
		send_beat(make_order(KIND_MOD, 3'd2, SIDE_ASK, 10'd20, 32'd0, '1, 1'b1));
		send_beat(make_order(KIND_MOD, 3'd2, SIDE_ASK, 10'd20, 32'd0, 40'd1, 1'b0));
		send_beat(make_order(KIND_MOD, 3'd2, SIDE_ASK, 10'd40, 32'd0, 40'd1, 1'b1));
		send_beat(make_order(KIND_ADD, 3'd3, SIDE_BID, 10'd5, 32'd0, 40'd0, 1'b1));
		req_valid <= 1'b0;

		// sender pause until every expected beat has drained
		@(negedge clk);
		while (pending != 0 || rsp_valid) @(negedge clk);

		for (int k = 0; k < RANDOM_ORDERS; k++) begin
			if (k == 60) hold_rsp = 1'b1;
			send_beat(random_order());
		end
		req_valid <= 1'b0;
		stim_done = 1'b1;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (40) @(negedge clk);
		$display("Ran adds and modifies over eight books, both sides, with eviction,");
		$display("saturation, orphaned levels and error paths; %0d result beats.", beats_seen);
		if (fail_count == 0 && pending == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end
endmodule

### sim.f
+incdir+rtl
rtl/plob_pkg.sv
rtl/plob_cell.sv
rtl/price_level_order_book_unit.sv
rtl/plob_checker.sv
dv/plob_checker.sv
dv/tb.sv
